>>> design/met_pkg.sv
// Shared constants and types for the Mandelbrot escape-time unit.
package met_pkg;

	localparam int COORD_BITS    = 12;
	localparam int LIMIT_BITS    = 31;
	localparam int STEP_BITS     = 63;
	localparam int CFG_BITS      = 64;
	localparam int CFG_ADDR_BITS = 5;
	localparam int LIMB_BITS     = 32;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [LIMIT_BITS-1:0] LIMIT_CAP = 31'd2000000000;

	typedef enum logic [1:0] {
		CFG_ORIGIN_REAL = 2'd0,
		CFG_ORIGIN_IMAG = 2'd1,
		CFG_PIXEL_STEP  = 2'd2,
		CFG_ITER_LIMIT  = 2'd3
	} cfg_index_t;

	typedef struct packed {
		logic start;
		logic half;
	} mul_ctl_t;

endpackage

>>> design/met_fifo.sv
// Short queue between the pixel front end and the iteration engine.
module met_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] dout,
	output logic          valid
);

	localparam int DEPTH = met_pkg::QUEUE_DEPTH;
	localparam int PTRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DW-1:0]   mem_q [DEPTH];
	logic [PTRW-1:0] wr_q;
	logic [PTRW-1:0] rd_q;
	logic [PTRW:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == (PTRW+1)'(DEPTH));
	assign valid   = (cnt_q != '0);
	assign dout    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PTRW'(DEPTH-1)) ? '0 : wr_q + PTRW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == PTRW'(DEPTH-1)) ? '0 : rd_q + PTRW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (PTRW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (PTRW+1)'(1);
			end
		end
	end

endmodule

>>> design/met_front.sv
// Front end: accepts a pixel, clamps it, forms the point c and queues the job.
module met_front #(
	parameter int W           = 64,
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [met_pkg::COORD_BITS-1:0]   column,
	input  logic [met_pkg::COORD_BITS-1:0]   row,
	input  logic [met_pkg::CFG_BITS-1:0]     origin_real,
	input  logic [met_pkg::CFG_BITS-1:0]     origin_imag,
	input  logic [met_pkg::STEP_BITS-1:0]    pixel_step,
	input  logic [met_pkg::LIMIT_BITS-1:0]   iteration_limit,
	output logic                             q_push,
	input  logic                             q_full,
	output logic [met_pkg::COORD_BITS-1:0]   q_col,
	output logic [met_pkg::COORD_BITS-1:0]   q_row,
	output logic [met_pkg::LIMIT_BITS-1:0]   q_lim,
	output logic [W-1:0]                     q_cr,
	output logic [W-1:0]                     q_ci
);

	localparam int CB  = met_pkg::COORD_BITS;
	localparam int LB  = met_pkg::LIMB_BITS;
	localparam int SB  = met_pkg::STEP_BITS;
	localparam int PB  = LB + CB;
	localparam int AB  = SB + CB + 1;
	localparam int PW  = ((W > AB) ? W : AB) + 2;
	localparam int OB  = met_pkg::CFG_BITS;

	localparam logic signed [PW-1:0] WMAX = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [PW-1:0] WMIN = {{(PW-W+1){1'b1}}, {(W-1){1'b0}}};

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_MUL  = 4'b0010,
		F_SUM  = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t           state_q;
	logic [1:0]        ph_q;
	logic [1:0]        tag_q;
	logic              pv_q;
	logic [PB-1:0]     prod_q;
	logic [AB-1:0]     acc_re_q;
	logic [AB-1:0]     acc_im_q;
	logic [CB-1:0]     col_q;
	logic [CB-1:0]     row_q;
	logic [CB-1:0]     cc_q;
	logic [CB-1:0]     rr_q;
	logic [met_pkg::LIMIT_BITS-1:0] lim_q;

	logic [LB-1:0]     limb;
	logic [CB-1:0]     coord;
	logic [PB-1:0]     prod_d;
	logic [AB-1:0]     addend;
	logic [W-1:0]      o_re_w;
	logic [W-1:0]      o_im_w;
	logic signed [PW-1:0] sum_re;
	logic signed [PW-1:0] sum_im;

	function automatic logic [W-1:0] sat_w(input logic signed [PW-1:0] v);
		logic [W-1:0] r;
		if (v > WMAX) begin
			r = WMAX[W-1:0];
		end else if (v < WMIN) begin
			r = WMIN[W-1:0];
		end else begin
			r = v[W-1:0];
		end
		return r;
	endfunction

	assign in_ready = (state_q == F_IDLE);
	assign q_push   = (state_q == F_PUSH) && !q_full;

	assign limb   = ph_q[0] ? {1'b0, pixel_step[SB-1:LB]} : pixel_step[LB-1:0];
	assign coord  = ph_q[1] ? rr_q : cc_q;
	assign prod_d = limb * coord;
	assign addend = tag_q[0] ? AB'({prod_q, {LB{1'b0}}}) : AB'(prod_q);

	assign o_re_w = sat_w({{(PW-OB){origin_real[OB-1]}}, origin_real});
	assign o_im_w = sat_w({{(PW-OB){origin_imag[OB-1]}}, origin_imag});
	assign sum_re = $signed({{(PW-W){o_re_w[W-1]}}, o_re_w}) + $signed({{(PW-AB){1'b0}}, acc_re_q});
	assign sum_im = $signed({{(PW-W){o_im_w[W-1]}}, o_im_w}) + $signed({{(PW-AB){1'b0}}, acc_im_q});

	assign q_col = col_q;
	assign q_row = row_q;
	assign q_lim = lim_q;
	assign q_cr  = sat_w(sum_re);
	assign q_ci  = sat_w(sum_im);

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			col_q <= column;
			row_q <= row;
			cc_q  <= ({20'b0, column} > 32'(MAX_COLUMNS-1)) ? CB'(MAX_COLUMNS-1) : column;
			rr_q  <= ({20'b0, row} > 32'(MAX_ROWS-1)) ? CB'(MAX_ROWS-1) : row;
			lim_q <= (iteration_limit > met_pkg::LIMIT_CAP) ? met_pkg::LIMIT_CAP
				: iteration_limit;
			acc_re_q <= '0;
			acc_im_q <= '0;
		end else if (pv_q) begin
			if (tag_q[1]) begin
				acc_im_q <= acc_im_q + addend;
			end else begin
				acc_re_q <= acc_re_q + addend;
			end
		end
		prod_q <= prod_d;
		tag_q  <= ph_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ph_q    <= '0;
			pv_q    <= 1'b0;
		end else begin
			pv_q <= (state_q == F_MUL);
			unique case (state_q)
				F_IDLE: begin
					ph_q <= '0;
					if (in_valid) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					ph_q <= ph_q + 2'd1;
					if (ph_q == 2'd3) begin
						state_q <= F_SUM;
					end
				end
				F_SUM: begin
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/met_mul.sv
// Shared fixed-point multiplier: 32x32 partial products, floor shift, saturation.
module met_mul #(
	parameter int W = 64,
	parameter int F = 60
) (
	input  logic              clk,
	input  logic              arst_n,
	input  met_pkg::mul_ctl_t ctl,
	input  logic [W-1:0]      a,
	input  logic [W-1:0]      b,
	output logic              done,
	output logic [W-1:0]      r
);

	localparam int LB = met_pkg::LIMB_BITS;
	localparam int NL = (W + LB - 1) / LB;
	localparam int IW = (NL > 1) ? $clog2(NL) : 1;
	localparam int SW = IW + 1;
	localparam int MW = NL * LB;
	localparam int AW = 2 * MW;

	localparam logic signed [AW:0] WMAX = {{(AW-W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [AW:0] WMIN = {{(AW-W+2){1'b1}}, {(W-1){1'b0}}};

	typedef enum logic [4:0] {
		M_IDLE  = 5'b00001,
		M_PROD  = 5'b00010,
		M_DRAIN = 5'b00100,
		M_NEG   = 5'b01000,
		M_FIN   = 5'b10000
	} mstate_t;

	mstate_t            state_q;
	logic [MW-1:0]      ma_q;
	logic [MW-1:0]      mb_q;
	logic               neg_q;
	logic               half_q;
	logic [IW-1:0]      i_q;
	logic [IW-1:0]      j_q;
	logic [2*LB-1:0]    p_q;
	logic [SW-1:0]      s_q;
	logic               pv_q;
	logic [AW-1:0]      acc_q;
	logic signed [AW:0] accs_q;

	logic               take;
	logic [W-1:0]       mag_a;
	logic [W-1:0]       mag_b;
	logic [LB-1:0]      la;
	logic [LB-1:0]      lb;
	logic [2*LB-1:0]    p_d;
	logic signed [AW:0] shifted;

	assign take  = ctl.start && (state_q == M_IDLE || state_q == M_FIN);
	assign mag_a = a[W-1] ? (~a + W'(1)) : a;
	assign mag_b = b[W-1] ? (~b + W'(1)) : b;
	assign la    = ma_q[i_q*LB +: LB];
	assign lb    = mb_q[j_q*LB +: LB];
	assign p_d   = la * lb;

	assign shifted = half_q ? (accs_q >>> (F-1)) : (accs_q >>> F);
	assign done    = (state_q == M_FIN);

	always_comb begin
		if (shifted > WMAX) begin
			r = WMAX[W-1:0];
		end else if (shifted < WMIN) begin
			r = WMIN[W-1:0];
		end else begin
			r = shifted[W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ma_q   <= MW'(mag_a);
			mb_q   <= MW'(mag_b);
			neg_q  <= a[W-1] ^ b[W-1];
			half_q <= ctl.half;
			acc_q  <= '0;
		end else if (pv_q) begin
			acc_q <= acc_q + (AW'(p_q) << (s_q * LB));
		end
		p_q <= p_d;
		s_q <= SW'(i_q) + SW'(j_q);
		if (state_q == M_NEG) begin
			accs_q <= neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			pv_q    <= 1'b0;
		end else begin
			pv_q <= (state_q == M_PROD);
			unique case (state_q)
				M_IDLE, M_FIN: begin
					i_q <= '0;
					j_q <= '0;
					state_q <= take ? M_PROD : M_IDLE;
				end
				M_PROD: begin
					if (j_q == IW'(NL-1)) begin
						j_q <= '0;
						if (i_q == IW'(NL-1)) begin
							state_q <= M_DRAIN;
						end else begin
							i_q <= i_q + IW'(1);
						end
					end else begin
						j_q <= j_q + IW'(1);
					end
				end
				M_DRAIN: begin
					state_q <= M_NEG;
				end
				M_NEG: begin
					state_q <= M_FIN;
				end
				default: begin
					state_q <= M_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/met_back.sv
// Iteration engine: runs z = z*z + c with cycle detection and holds the result.
module met_back #(
	parameter int W = 64,
	parameter int F = 60
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_valid,
	output logic                           q_pop,
	input  logic [met_pkg::COORD_BITS-1:0] q_col,
	input  logic [met_pkg::COORD_BITS-1:0] q_row,
	input  logic [met_pkg::LIMIT_BITS-1:0] q_lim,
	input  logic [W-1:0]                   q_cr,
	input  logic [W-1:0]                   q_ci,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [met_pkg::COORD_BITS-1:0] out_column,
	output logic [met_pkg::COORD_BITS-1:0] out_row,
	output logic [met_pkg::LIMIT_BITS-1:0] iteration_count,
	output logic                           escaped
);

	localparam int CB = met_pkg::COORD_BITS;
	localparam int LW = met_pkg::LIMIT_BITS;
	localparam logic [W:0] FOUR = (W+1)'(4) << F;

	typedef enum logic [6:0] {
		B_IDLE = 7'b0000001,
		B_TEST = 7'b0000010,
		B_MXY  = 7'b0000100,
		B_SX   = 7'b0001000,
		B_MXX  = 7'b0010000,
		B_MYY  = 7'b0100000,
		B_OUT  = 7'b1000000
	} bstate_t;

	bstate_t         state_q;
	logic [W-1:0]    x_q;
	logic [W-1:0]    y_q;
	logic [W-1:0]    x2_q;
	logic [W-1:0]    y2_q;
	logic [W-1:0]    d_q;
	logic [W-1:0]    cr_q;
	logic [W-1:0]    ci_q;
	logic [W-1:0]    sx_q;
	logic [W-1:0]    sy_q;
	logic [CB-1:0]   col_q;
	logic [CB-1:0]   row_q;
	logic [LW-1:0]   lim_q;
	logic [LW-1:0]   cnt_q;
	logic [31:0]     pow_q;
	logic [31:0]     lam_q;
	logic            ov_q;
	logic [CB-1:0]   ocol_q;
	logic [CB-1:0]   orow_q;
	logic [LW-1:0]   ocnt_q;
	logic            oesc_q;

	met_pkg::mul_ctl_t mctl;
	logic [W-1:0]    mul_a;
	logic [W-1:0]    mul_b;
	logic            mul_done;
	logic [W-1:0]    mul_r;
	logic            go;
	logic            out_free;
	logic            repeat_hit;

	function automatic logic [W-1:0] sat_fix(input logic [W:0] s);
		logic [W-1:0] r;
		if (s[W] != s[W-1]) begin
			r = s[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			r = s[W-1:0];
		end
		return r;
	endfunction

	assign go = (({1'b0, x2_q} + {1'b0, y2_q}) <= FOUR) && (cnt_q < lim_q);
	assign out_free   = !ov_q || out_ready;
	assign repeat_hit = (x_q == sx_q) && (y_q == sy_q);

	assign mctl.start = (state_q == B_TEST && go) || (state_q == B_SX)
		|| (state_q == B_MXX && mul_done);
	assign mctl.half  = (state_q == B_TEST);
	assign mul_a      = (state_q == B_TEST || state_q == B_SX) ? x_q : y_q;
	assign mul_b      = (state_q == B_TEST) ? y_q : ((state_q == B_SX) ? x_q : y_q);

	met_mul #(.W(W), .F(F)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.r      (mul_r)
	);

	assign q_pop           = (state_q == B_IDLE) && q_valid;
	assign out_valid       = ov_q;
	assign out_column      = ocol_q;
	assign out_row         = orow_q;
	assign iteration_count = ocnt_q;
	assign escaped         = oesc_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			B_IDLE: begin
				col_q <= q_col;
				row_q <= q_row;
				lim_q <= q_lim;
				cr_q  <= q_cr;
				ci_q  <= q_ci;
				x_q   <= '0;
				y_q   <= '0;
				x2_q  <= '0;
				y2_q  <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end
			B_TEST: begin
				d_q <= sat_fix({x2_q[W-1], x2_q} - {y2_q[W-1], y2_q});
			end
			B_MXY: begin
				if (mul_done) begin
					x_q <= sat_fix({d_q[W-1], d_q} + {cr_q[W-1], cr_q});
					y_q <= sat_fix({mul_r[W-1], mul_r} + {ci_q[W-1], ci_q});
				end
			end
			B_MXX: begin
				if (mul_done) begin
					x2_q <= mul_r;
				end
			end
			B_MYY: begin
				if (mul_done) begin
					y2_q <= mul_r;
					if (!repeat_hit && (lam_q + 32'd1 == pow_q)) begin
						sx_q <= x_q;
						sy_q <= y_q;
					end
				end
			end
			B_SX, B_OUT: begin
			end
			default: begin
			end
		endcase
		if (state_q == B_OUT && out_free) begin
			ocol_q <= col_q;
			orow_q <= row_q;
			ocnt_q <= cnt_q;
			oesc_q <= (cnt_q < lim_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			cnt_q   <= '0;
			pow_q   <= 32'd1;
			lam_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (ov_q && out_ready && state_q != B_OUT) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					cnt_q <= '0;
					pow_q <= 32'd1;
					lam_q <= '0;
					if (q_valid) begin
						state_q <= B_TEST;
					end
				end
				B_TEST: begin
					state_q <= go ? B_MXY : B_OUT;
				end
				B_MXY: begin
					if (mul_done) begin
						state_q <= B_SX;
					end
				end
				B_SX: begin
					state_q <= B_MXX;
				end
				B_MXX: begin
					if (mul_done) begin
						state_q <= B_MYY;
					end
				end
				B_MYY: begin
					if (mul_done) begin
						if (repeat_hit) begin
							cnt_q   <= lim_q;
							state_q <= B_OUT;
						end else begin
							cnt_q <= cnt_q + LW'(1);
							if (lam_q + 32'd1 == pow_q) begin
								pow_q <= pow_q << 1;
								lam_q <= '0;
							end else begin
								lam_q <= lam_q + 32'd1;
							end
							state_q <= B_TEST;
						end
					end
				end
				B_OUT: begin
					if (out_free) begin
						ov_q    <= 1'b1;
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

>>> design/mandelbrot_escape_time_unit.sv
// Top level of the Mandelbrot escape-time unit: register port, front end, queue, engine.
//
// Each pixel transaction (column, row) yields one result transaction with the
// pixel's coordinates, the iteration count and the escaped flag. The front end
// forms c = origin + pixel_step * coordinate, then the job waits in a two-entry
// queue for the iteration engine. Each iteration is paced by the single shared
// 32x32 multiplier, which splits each operand into WORD_BITS/32 limbs (rounded
// up) and forms x*y, x*x and y*y in turn; a pixel's time grows with its
// iteration count and is shorter when the orbit is found to repeat. The front
// end takes the next pixel while the engine works, and the engine starts the
// next job while a finished result waits in the output register. Registers sit
// at byte addresses 0, 8, 16 and 24 (origin_real, origin_imag, pixel_step,
// iteration_limit); the user must write them only while the unit is idle, as
// the unit itself does not enforce this.
module mandelbrot_escape_time_unit #(
	parameter int WORD_BITS   = 64,
	parameter int FRAC_BITS   = 60,
	parameter int MAX_COLUMNS = 4096,
	parameter int MAX_ROWS    = 4096
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [met_pkg::CFG_ADDR_BITS-1:0] paddr,
	input  logic [met_pkg::CFG_BITS-1:0]      pwdata,
	output logic [met_pkg::CFG_BITS-1:0]      prdata,
	output logic                              pready,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [met_pkg::COORD_BITS-1:0]    column,
	input  logic [met_pkg::COORD_BITS-1:0]    row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [met_pkg::COORD_BITS-1:0]    out_column,
	output logic [met_pkg::COORD_BITS-1:0]    out_row,
	output logic [met_pkg::LIMIT_BITS-1:0]    iteration_count,
	output logic                              escaped
);

	localparam int CB = met_pkg::COORD_BITS;
	localparam int LW = met_pkg::LIMIT_BITS;
	localparam int SB = met_pkg::STEP_BITS;
	localparam int OB = met_pkg::CFG_BITS;
	localparam int W  = WORD_BITS;
	localparam int DW = 2*CB + LW + 2*W;

	logic [OB-1:0] origin_real_q;
	logic [OB-1:0] origin_imag_q;
	logic [SB-1:0] pixel_step_q;
	logic [LW-1:0] iteration_limit_q;
	met_pkg::cfg_index_t cfg_idx;

	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	logic [CB-1:0] f_col;
	logic [CB-1:0] f_row;
	logic [LW-1:0] f_lim;
	logic [W-1:0]  f_cr;
	logic [W-1:0]  f_ci;
	logic [DW-1:0] q_din;
	logic [DW-1:0] q_dout;

	assign pready  = 1'b1;
	assign cfg_idx = met_pkg::cfg_index_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_real_q     <= 64'hE800_0000_0000_0000;
			origin_imag_q     <= 64'hF000_0000_0000_0000;
			pixel_step_q      <= 63'd1201368221470720;
			iteration_limit_q <= 31'd1000;
		end else if (psel && penable && pwrite) begin
			unique case (cfg_idx)
				met_pkg::CFG_ORIGIN_REAL: origin_real_q     <= pwdata;
				met_pkg::CFG_ORIGIN_IMAG: origin_imag_q     <= pwdata;
				met_pkg::CFG_PIXEL_STEP:  pixel_step_q      <= pwdata[SB-1:0];
				met_pkg::CFG_ITER_LIMIT:  iteration_limit_q <= pwdata[LW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			met_pkg::CFG_ORIGIN_REAL: prdata = origin_real_q;
			met_pkg::CFG_ORIGIN_IMAG: prdata = origin_imag_q;
			met_pkg::CFG_PIXEL_STEP:  prdata = OB'(pixel_step_q);
			met_pkg::CFG_ITER_LIMIT:  prdata = OB'(iteration_limit_q);
			default:                  prdata = '0;
		endcase
	end

	met_front #(
		.W           (W),
		.MAX_COLUMNS (MAX_COLUMNS),
		.MAX_ROWS    (MAX_ROWS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.column          (column),
		.row             (row),
		.origin_real     (origin_real_q),
		.origin_imag     (origin_imag_q),
		.pixel_step      (pixel_step_q),
		.iteration_limit (iteration_limit_q),
		.q_push          (q_push),
		.q_full          (q_full),
		.q_col           (f_col),
		.q_row           (f_row),
		.q_lim           (f_lim),
		.q_cr            (f_cr),
		.q_ci            (f_ci)
	);

	assign q_din = {f_col, f_row, f_lim, f_cr, f_ci};

	met_fifo #(.DW(DW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.valid  (q_valid)
	);

	met_back #(.W(W), .F(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_col           (q_dout[DW-1 -: CB]),
		.q_row           (q_dout[DW-CB-1 -: CB]),
		.q_lim           (q_dout[2*W+LW-1 -: LW]),
		.q_cr            (q_dout[2*W-1 -: W]),
		.q_ci            (q_dout[W-1:0]),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_column      (out_column),
		.out_row         (out_row),
		.iteration_count (iteration_count),
		.escaped         (escaped)
	);

endmodule

>>> design/met_checker.sv
// Port-level checks for the Mandelbrot escape-time unit, bound to the top level.
module met_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           pready,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [met_pkg::COORD_BITS-1:0] out_column,
	input logic [met_pkg::COORD_BITS-1:0] out_row,
	input logic [met_pkg::LIMIT_BITS-1:0] iteration_count,
	input logic                           escaped
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_row)
			&& $stable(iteration_count) && $stable(escaped))
		else $error("result changed while stalled");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> iteration_count <= met_pkg::LIMIT_CAP)
		else $error("iteration count above cap");

	a_escape_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && escaped |-> iteration_count != '0)
		else $error("escape reported with no iteration");

	a_front_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("front end took two pixels back to back");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind mandelbrot_escape_time_unit met_checker u_met_checker (.*);
